// File: hw/rtl/plt_pkg.sv
// Shared types and constants for the price ladder best level tracker.
// No dependencies; used by every RTL file of the block.
package plt_pkg;

  localparam int NUM_LEVELS = 1024;
  localparam int IDX_W      = $clog2(NUM_LEVELS);
  localparam int QTY_W      = 48;
  localparam int CNT_W      = 16;
  localparam int PRICE_W    = 32;
  localparam int ORDQ_W     = 32;
  localparam int STAT_W     = 3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LEVELS - 1);

  localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
  localparam logic [STAT_W-1:0] ST_OUTSIDE     = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY_LEVEL = 3'd2;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW   = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL        = 3'd4;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;

  localparam logic CFG_BOOK_SIDE = 1'b0;
  localparam logic CFG_BASE      = 1'b1;

  typedef struct packed {
    logic [QTY_W-1:0] qty;
    logic [CNT_W-1:0] cnt;
  } entry_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    entry_t            entry;
    logic              wr;
    logic              emptied;
  } alu_res_t;

endpackage

// File: hw/rtl/plt_level_ram.sv
// Level store: one write port, one registered read port.
// Depends on plt_pkg for the entry type and depth.
module plt_level_ram (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [plt_pkg::IDX_W-1:0] wr_addr,
  input  plt_pkg::entry_t       wr_data,
  input  logic [plt_pkg::IDX_W-1:0] rd_addr,
  output plt_pkg::entry_t       rd_data
);

  plt_pkg::entry_t mem [plt_pkg::NUM_LEVELS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hw/rtl/plt_level_alu.sv
// Level update unit: saturating add or checked remove on one level entry.
// Depends on plt_pkg for entry, result type and status codes.
module plt_level_alu (
  input  logic                       operation,
  input  logic [plt_pkg::ORDQ_W-1:0] order_quantity,
  input  plt_pkg::entry_t            entry,
  output plt_pkg::alu_res_t          res
);

  logic [plt_pkg::QTY_W:0]   sum;
  logic [plt_pkg::QTY_W-1:0] qty_ext;

  always_comb begin
    qty_ext     = plt_pkg::QTY_W'(order_quantity);
    sum         = {1'b0, entry.qty} + {1'b0, qty_ext};
    res.status  = plt_pkg::ST_OK;
    res.entry   = entry;
    res.wr      = 1'b0;
    res.emptied = 1'b0;
    if (operation == plt_pkg::OP_ADD) begin
      if (entry.cnt == {plt_pkg::CNT_W{1'b1}}) begin
        res.status = plt_pkg::ST_FULL;
      end else begin
        res.wr        = 1'b1;
        res.entry.cnt = entry.cnt + plt_pkg::CNT_W'(1);
        res.entry.qty = sum[plt_pkg::QTY_W] ? {plt_pkg::QTY_W{1'b1}}
                                           : sum[plt_pkg::QTY_W-1:0];
      end
    end else begin
      if (entry.cnt == '0) begin
        res.status = plt_pkg::ST_EMPTY_LEVEL;
      end else if (qty_ext > entry.qty) begin
        res.status = plt_pkg::ST_UNDERFLOW;
      end else begin
        res.wr        = 1'b1;
        res.entry.cnt = entry.cnt - plt_pkg::CNT_W'(1);
        res.entry.qty = entry.qty - qty_ext;
        if (entry.cnt == plt_pkg::CNT_W'(1)) begin
          res.entry.qty = '0;
          res.emptied   = 1'b1;
        end
      end
    end
  end

endmodule

// File: hw/rtl/plt_seq.sv
// Sequencer: clearing sweep, level update, best-level rescan, result register.
// Depends on plt_pkg, plt_level_ram and plt_level_alu.
module plt_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        book_side,
  input  logic [plt_pkg::PRICE_W-1:0] window_base_price,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        operation,
  input  logic [plt_pkg::PRICE_W-1:0] order_price,
  input  logic [plt_pkg::ORDQ_W-1:0]  order_quantity,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [plt_pkg::STAT_W-1:0]  status,
  output logic [plt_pkg::QTY_W-1:0]   level_total,
  output logic [plt_pkg::CNT_W-1:0]   level_orders,
  output logic                        best_valid,
  output logic [plt_pkg::PRICE_W-1:0] top_price,
  output logic [plt_pkg::QTY_W-1:0]   best_total
);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_UPDATE = 6'b000100,
    S_SCAN   = 6'b001000,
    S_BEST   = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state;

  logic                        op_r;
  logic [plt_pkg::ORDQ_W-1:0]  qty_r;
  logic [plt_pkg::IDX_W-1:0]   idx_r;
  logic                        outside_r;
  logic [plt_pkg::IDX_W-1:0]   best_idx;
  logic                        nonempty;
  logic [plt_pkg::IDX_W-1:0]   scan_addr;
  logic [plt_pkg::IDX_W-1:0]   chk_idx;
  logic                        chk_valid;
  logic [plt_pkg::IDX_W-1:0]   clr_idx;
  logic [plt_pkg::STAT_W-1:0]  lvl_status;
  logic [plt_pkg::QTY_W-1:0]   lvl_tot;
  logic [plt_pkg::CNT_W-1:0]   lvl_cnt;

  logic [plt_pkg::PRICE_W:0]   offset;
  logic                        in_outside;
  logic [plt_pkg::IDX_W-1:0]   in_idx;
  logic [plt_pkg::IDX_W-1:0]   rd_addr;
  logic                        wr_en;
  logic [plt_pkg::IDX_W-1:0]   wr_addr;
  plt_pkg::entry_t             wr_data;
  plt_pkg::entry_t             rd_data;
  plt_pkg::alu_res_t           alu;
  logic [plt_pkg::IDX_W-1:0]   scan_end;
  logic [plt_pkg::IDX_W-1:0]   best_step;
  logic [plt_pkg::IDX_W-1:0]   scan_step;
  logic                        better;
  logic                        found;
  logic                        rescan;

  plt_level_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  plt_level_alu u_alu (
    .operation      (op_r),
    .order_quantity (qty_r),
    .entry          (rd_data),
    .res            (alu)
  );

  assign in_ready = (state == S_IDLE);

  always_comb begin
    offset     = {1'b0, order_price} - {1'b0, window_base_price};
    in_outside = offset[plt_pkg::PRICE_W] ||
                 (offset[plt_pkg::PRICE_W-1:0] >= plt_pkg::PRICE_W'(plt_pkg::NUM_LEVELS));
    in_idx     = offset[plt_pkg::IDX_W-1:0];
    scan_end   = (book_side == plt_pkg::SIDE_BID) ? '0 : plt_pkg::LAST_IDX;
    best_step  = (book_side == plt_pkg::SIDE_BID) ? best_idx - plt_pkg::IDX_W'(1)
                                                   : best_idx + plt_pkg::IDX_W'(1);
    scan_step  = (book_side == plt_pkg::SIDE_BID) ? scan_addr - plt_pkg::IDX_W'(1)
                                                   : scan_addr + plt_pkg::IDX_W'(1);
    better     = (book_side == plt_pkg::SIDE_BID) ? (idx_r > best_idx) : (idx_r < best_idx);
    found      = chk_valid && (rd_data.cnt != '0);
    rescan     = !outside_r && (alu.status == plt_pkg::ST_OK) &&
                 (op_r == plt_pkg::OP_REMOVE) && alu.emptied && nonempty &&
                 (idx_r == best_idx) && (best_idx != scan_end);
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = alu.entry;
    case (state)
      S_IDLE:  rd_addr = in_idx;
      S_SCAN:  rd_addr = scan_addr;
      default: rd_addr = best_idx;
    endcase
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx;
        wr_data = '0;
      end
      S_UPDATE: begin
        wr_en = !outside_r && alu.wr;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      best_idx  <= '0;
      nonempty  <= 1'b0;
      chk_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + plt_pkg::IDX_W'(1);
          if (clr_idx == plt_pkg::LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_r      <= operation;
            qty_r     <= order_quantity;
            idx_r     <= in_idx;
            outside_r <= in_outside;
            state     <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          state <= rescan ? S_SCAN : S_BEST;
          if (outside_r) begin
            lvl_status <= plt_pkg::ST_OUTSIDE;
            lvl_tot    <= '0;
            lvl_cnt    <= '0;
          end else begin
            lvl_status <= alu.status;
            lvl_tot    <= alu.entry.qty;
            lvl_cnt    <= alu.entry.cnt;
            if (alu.status == plt_pkg::ST_OK) begin
              if (op_r == plt_pkg::OP_ADD) begin
                if (!nonempty) begin
                  nonempty <= 1'b1;
                  best_idx <= idx_r;
                end else if (better) begin
                  best_idx <= idx_r;
                end
              end else if (alu.emptied && nonempty && idx_r == best_idx) begin
                if (best_idx == scan_end) begin
                  nonempty <= 1'b0;
                  best_idx <= '0;
                end else begin
                  scan_addr <= best_step;
                  chk_valid <= 1'b0;
                end
              end
            end
          end
        end
        S_SCAN: begin
          chk_idx   <= scan_addr;
          chk_valid <= 1'b1;
          if (scan_addr != scan_end) begin
            scan_addr <= scan_step;
          end
          if (found) begin
            best_idx <= chk_idx;
            state    <= S_BEST;
          end else if (chk_valid && chk_idx == scan_end) begin
            nonempty <= 1'b0;
            best_idx <= '0;
            state    <= S_BEST;
          end
        end
        S_BEST: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            status       <= lvl_status;
            level_total  <= lvl_tot;
            level_orders <= lvl_cnt;
            best_valid   <= nonempty;
            top_price    <= nonempty ?
                            window_base_price + plt_pkg::PRICE_W'(best_idx) : '0;
            best_total   <= nonempty ? rd_data.qty : '0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_empty_best_zero: assert property (@(posedge clk) disable iff (rst)
    !nonempty |-> best_idx == '0)
    else $error("best index not zero on empty book");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> nonempty)
    else $error("rescan running on empty book");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_CLEAR || state == S_UPDATE))
    else $error("level store written outside clear or update");

  a_finish_hold: assert property (@(posedge clk) disable iff (rst)
    state == S_FINISH && out_valid && !out_ready |=> state == S_FINISH)
    else $error("result overwritten while held");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !best_valid |-> top_price == '0 && best_total == '0)
    else $error("empty book reports a best level");
`endif

endmodule

// File: hw/rtl/price_ladder_best_level_tracker.sv
// Top level of the price ladder best level tracker: configuration registers.
// Depends on plt_pkg and plt_seq.
//
//  channel | direction | handshake            | payload
//  cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in      | in        | in_valid/in_ready    | operation, order_price, order_quantity
//  out     | out       | out_valid/out_ready  | status, level_total, level_orders,
//          |           |                      | best_valid, top_price, best_total
//
// An item passes through accept, level update, best read and result load when the
// best level does not empty; an emptying remove of the best level adds a rescan
// that steps level by level through the level RAM read port (no rescan when the
// best level sits at the end of the ladder).
// After reset a clearing sweep writes NUM_LEVELS (1024) entries, one per cycle,
// with in_ready low; configuration transfers are taken at any time.
// A stalled result holds in the output register; the next item is accepted
// meanwhile and waits in the result load step until the output is free.
module price_ladder_best_level_tracker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [plt_pkg::PRICE_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        operation,
  input  logic [plt_pkg::PRICE_W-1:0] order_price,
  input  logic [plt_pkg::ORDQ_W-1:0]  order_quantity,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [plt_pkg::STAT_W-1:0]  status,
  output logic [plt_pkg::QTY_W-1:0]   level_total,
  output logic [plt_pkg::CNT_W-1:0]   level_orders,
  output logic                        best_valid,
  output logic [plt_pkg::PRICE_W-1:0] top_price,
  output logic [plt_pkg::QTY_W-1:0]   best_total
);

  logic                        book_side;
  logic [plt_pkg::PRICE_W-1:0] window_base_price;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      book_side         <= plt_pkg::SIDE_BID;
      window_base_price <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        plt_pkg::CFG_BOOK_SIDE: book_side         <= cfg_data[0];
        plt_pkg::CFG_BASE:      window_base_price <= cfg_data;
        default:                book_side         <= book_side;
      endcase
    end
  end

  plt_seq u_seq (
    .clk               (clk),
    .rst               (rst),
    .book_side         (book_side),
    .window_base_price (window_base_price),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .operation         (operation),
    .order_price       (order_price),
    .order_quantity    (order_quantity),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .level_total       (level_total),
    .level_orders      (level_orders),
    .best_valid        (best_valid),
    .top_price         (top_price),
    .best_total        (best_total)
  );

endmodule

// File: sim/plt_ladder_checker.sv
// Checker for the price ladder best level tracker: mirrors the ladder from the
// observed config and input transfers, queues predicted reports, compares results.
// Depends on plt_pkg.
module plt_ladder_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [plt_pkg::PRICE_W-1:0] cfg_data,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        operation,
  input  logic [plt_pkg::PRICE_W-1:0] order_price,
  input  logic [plt_pkg::ORDQ_W-1:0]  order_quantity,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [plt_pkg::STAT_W-1:0]  status,
  input  logic [plt_pkg::QTY_W-1:0]   level_total,
  input  logic [plt_pkg::CNT_W-1:0]   level_orders,
  input  logic                        best_valid,
  input  logic [plt_pkg::PRICE_W-1:0] top_price,
  input  logic [plt_pkg::QTY_W-1:0]   best_total,
  output int                          mismatches,
  output int                          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [plt_pkg::STAT_W-1:0]  status;
    logic [plt_pkg::QTY_W-1:0]   level_total;
    logic [plt_pkg::CNT_W-1:0]   level_orders;
    logic                        best_valid;
    logic [plt_pkg::PRICE_W-1:0] top_price;
    logic [plt_pkg::QTY_W-1:0]   best_total;
  } ladder_report_t;

  logic [plt_pkg::QTY_W-1:0]   lvl_qty [plt_pkg::NUM_LEVELS];
  logic [plt_pkg::CNT_W-1:0]   lvl_cnt [plt_pkg::NUM_LEVELS];
  logic [plt_pkg::IDX_W-1:0]   best_idx;
  logic                        has_orders;
  logic                        side_cfg;
  logic [plt_pkg::PRICE_W-1:0] base_cfg;
  ladder_report_t              queued_reports[$];

  function automatic ladder_report_t apply_order(logic op,
                                                 logic [plt_pkg::PRICE_W-1:0] price,
                                                 logic [plt_pkg::ORDQ_W-1:0] qty);
    ladder_report_t            r;
    logic [31:0]               offset;
    logic [plt_pkg::IDX_W-1:0] idx;
    logic [plt_pkg::QTY_W:0]   sum;
    logic                      found;
    r = '0;
    offset = price - base_cfg;
    if (price < base_cfg || offset >= 32'(plt_pkg::NUM_LEVELS)) begin
      r.status = plt_pkg::ST_OUTSIDE;
    end else begin
      idx = offset[plt_pkg::IDX_W-1:0];
      if (op == plt_pkg::OP_ADD) begin
        if (lvl_cnt[idx] == '1) begin
          r.status = plt_pkg::ST_FULL;
        end else begin
          lvl_cnt[idx] = lvl_cnt[idx] + plt_pkg::CNT_W'(1);
          sum = {1'b0, lvl_qty[idx]} + (plt_pkg::QTY_W+1)'(qty);
          lvl_qty[idx] = sum[plt_pkg::QTY_W] ? '1 : sum[plt_pkg::QTY_W-1:0];
          if (!has_orders) begin
            has_orders = 1'b1;
            best_idx = idx;
          end else if (side_cfg == plt_pkg::SIDE_BID ? idx > best_idx : idx < best_idx) begin
            best_idx = idx;
          end
        end
      end else if (lvl_cnt[idx] == '0) begin
        r.status = plt_pkg::ST_EMPTY_LEVEL;
      end else if (plt_pkg::QTY_W'(qty) > lvl_qty[idx]) begin
        r.status = plt_pkg::ST_UNDERFLOW;
      end else begin
        lvl_cnt[idx] = lvl_cnt[idx] - plt_pkg::CNT_W'(1);
        lvl_qty[idx] = lvl_qty[idx] - plt_pkg::QTY_W'(qty);
        if (lvl_cnt[idx] == '0) begin
          lvl_qty[idx] = '0;
          if (has_orders && idx == best_idx) begin
            found = 1'b0;
            if (side_cfg == plt_pkg::SIDE_BID) begin
              for (int i = int'(best_idx) - 1; i >= 0 && !found; i--)
                if (lvl_cnt[plt_pkg::IDX_W'(i)] != '0) begin
                  best_idx = plt_pkg::IDX_W'(i);
                  found = 1'b1;
                end
            end else begin
              for (int i = int'(best_idx) + 1; i < plt_pkg::NUM_LEVELS && !found; i++)
                if (lvl_cnt[plt_pkg::IDX_W'(i)] != '0) begin
                  best_idx = plt_pkg::IDX_W'(i);
                  found = 1'b1;
                end
            end
            if (!found) begin
              has_orders = 1'b0;
              best_idx = '0;
            end
          end
        end
      end
      r.level_total = lvl_qty[idx];
      r.level_orders = lvl_cnt[idx];
    end
    if (has_orders) begin
      r.best_valid = 1'b1;
      r.top_price = base_cfg + plt_pkg::PRICE_W'(best_idx);
      r.best_total = lvl_qty[best_idx];
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    ladder_report_t want;
    if (rst) begin
      for (int i = 0; i < plt_pkg::NUM_LEVELS; i++) begin
        lvl_qty[plt_pkg::IDX_W'(i)] = '0;
        lvl_cnt[plt_pkg::IDX_W'(i)] = '0;
      end
      best_idx = '0;
      has_orders = 1'b0;
      side_cfg = plt_pkg::SIDE_BID;
      base_cfg = '0;
      queued_reports.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (queued_reports.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer expected none actual status 0x%0h", $time, status);
        end else begin
          want = queued_reports.pop_front();
          check_field("status", 64'(want.status), 64'(status));
          check_field("level_total", 64'(want.level_total), 64'(level_total));
          check_field("level_orders", 64'(want.level_orders), 64'(level_orders));
          check_field("best_valid", 64'(want.best_valid), 64'(best_valid));
          check_field("top_price", 64'(want.top_price), 64'(top_price));
          check_field("best_total", 64'(want.best_total), 64'(best_total));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == plt_pkg::CFG_BOOK_SIDE)
          side_cfg = cfg_data[0];
        else
          base_cfg = cfg_data;
      end
      if (in_valid && in_ready)
        queued_reports.insert(queued_reports.size(),
                              apply_order(operation, order_price, order_quantity));
    end
    outstanding <= queued_reports.size();
  end

endmodule

// File: sim/tb_price_ladder_best_level_tracker.sv
// Testbench top for the price ladder best level tracker: clock, reset, stimulus
// with idling and back-pressure, verdict. Depends on plt_pkg, plt_ladder_checker
// and the block's RTL.
module tb_price_ladder_best_level_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic                        cfg_index = plt_pkg::CFG_BOOK_SIDE;
  logic [plt_pkg::PRICE_W-1:0] cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        operation = plt_pkg::OP_ADD;
  logic [plt_pkg::PRICE_W-1:0] order_price = '0;
  logic [plt_pkg::ORDQ_W-1:0]  order_quantity = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [plt_pkg::STAT_W-1:0]  status;
  logic [plt_pkg::QTY_W-1:0]   level_total;
  logic [plt_pkg::CNT_W-1:0]   level_orders;
  logic                        best_valid;
  logic [plt_pkg::PRICE_W-1:0] top_price;
  logic [plt_pkg::QTY_W-1:0]   best_total;
  int                          mismatches;
  int                          outstanding;

  bit idle_on = 1'b1;
  bit long_hold_req = 1'b0;

  price_ladder_best_level_tracker DUT (.*);
  plt_ladder_checker checker_i (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
    end
  end

  task automatic send_order(input logic op, input logic [plt_pkg::PRICE_W-1:0] price,
                            input logic [plt_pkg::ORDQ_W-1:0] qty);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    order_price <= price;
    order_quantity <= qty;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic set_book(input logic side, input logic [plt_pkg::PRICE_W-1:0] base);
    cfg_valid <= 1'b1;
    cfg_index <= plt_pkg::CFG_BOOK_SIDE;
    cfg_data <= {{(plt_pkg::PRICE_W-1){1'b0}}, side};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= plt_pkg::CFG_BASE;
    cfg_data <= base;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    int                          center, spread, lo, hi, pick;
    logic                        side, op;
    logic [plt_pkg::PRICE_W-1:0] base, price;
    logic [plt_pkg::ORDQ_W-1:0]  qty;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    set_book(plt_pkg::SIDE_BID, 32'd1000);
    send_order(plt_pkg::OP_ADD, 32'd999, 32'd1);
    send_order(plt_pkg::OP_ADD, 32'd2024, 32'd1);
    send_order(plt_pkg::OP_REMOVE, 32'd1005, 32'd1);
    send_order(plt_pkg::OP_ADD, 32'd1005, 32'd100);
    send_order(plt_pkg::OP_ADD, 32'd1003, 32'd0);
    send_order(plt_pkg::OP_ADD, 32'd1010, 32'hFFFF_FFFF);
    send_order(plt_pkg::OP_REMOVE, 32'd1005, 32'd200);
    send_order(plt_pkg::OP_REMOVE, 32'd1010, 32'd5);
    send_order(plt_pkg::OP_ADD, 32'd2023, 32'd1);
    send_order(plt_pkg::OP_REMOVE, 32'd2023, 32'd1);
    send_order(plt_pkg::OP_REMOVE, 32'd1005, 32'd100);
    send_order(plt_pkg::OP_REMOVE, 32'd1003, 32'd0);
    send_order(plt_pkg::OP_ADD, 32'd1000, 32'd7);
    send_order(plt_pkg::OP_ADD, 32'd0, 32'd1);
    send_order(plt_pkg::OP_ADD, 32'hFFFF_FFFF, 32'd1);
    settle();
    set_book(plt_pkg::SIDE_ASK, 32'hFFFF_FC00);
    send_order(plt_pkg::OP_ADD, 32'hFFFF_FFFF, 32'd3);
    send_order(plt_pkg::OP_ADD, 32'hFFFF_FC05, 32'd2);
    send_order(plt_pkg::OP_REMOVE, 32'hFFFF_FC00, 32'd7);
    send_order(plt_pkg::OP_REMOVE, 32'hFFFF_FC05, 32'd2);
    send_order(plt_pkg::OP_ADD, 32'hFFFF_FBFF, 32'd1);
    settle();
    set_book(plt_pkg::SIDE_BID, 32'hFFFF_FFFF);
    send_order(plt_pkg::OP_ADD, 32'hFFFF_FFFF, 32'd1);
    send_order(plt_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'd1);
    send_order(plt_pkg::OP_ADD, 32'd0, 32'd1);
    settle();
    set_book(plt_pkg::SIDE_BID, 32'd0);
    send_order(plt_pkg::OP_REMOVE, 32'd1023, 32'd3);
    send_order(plt_pkg::OP_ADD, 32'd0, 32'd0);

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      side = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0: base = '0;
        1: base = 32'hFFFF_FC00;
        default: base = $urandom_range(0, 32'hFFFF_FC00);
      endcase
      set_book(side, base);
      idle_on = (ph != 3);
      if (ph == 0)
        long_hold_req = 1'b1;
      center = $urandom_range(0, plt_pkg::NUM_LEVELS - 1);
      spread = $urandom_range(1, 15);
      lo = (center - spread < 0) ? 0 : center - spread;
      hi = (center + spread > plt_pkg::NUM_LEVELS - 1) ? plt_pkg::NUM_LEVELS - 1
                                                       : center + spread;
      for (int n = 0; n < 100; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8)
          price = $urandom();
        else if (pick < 14)
          price = base + $urandom_range(0, plt_pkg::NUM_LEVELS - 1);
        else
          price = base + $urandom_range(lo, hi);
        op = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (op == plt_pkg::OP_ADD)
          qty = (pick < 5) ? $urandom() : $urandom_range(1, 100);
        else if (pick < 10)
          qty = $urandom();
        else if (pick < 20)
          qty = '0;
        else
          qty = $urandom_range(0, 40);
        send_order(op, price, qty);
      end
    end

    settle();
    idle_on = 1'b0;
    set_book(1'($urandom_range(0, 1)), 32'd0);
    for (int n = 0; n < 16; n++)
      send_order(plt_pkg::OP_ADD, 32'd700, 32'hFFFF_FFFF);
    send_order(plt_pkg::OP_ADD, 32'd700, 32'd1);
    send_order(plt_pkg::OP_REMOVE, 32'd700, 32'hFFFF_FFFF);
    send_order(plt_pkg::OP_ADD, 32'd700, 32'hFFFF_FFFF);

    settle();
    repeat (1100) @(posedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/plt_pkg.sv
hw/rtl/plt_level_ram.sv
hw/rtl/plt_level_alu.sv
hw/rtl/plt_seq.sv
hw/rtl/price_ladder_best_level_tracker.sv
sim/plt_ladder_checker.sv
sim/tb_price_ladder_best_level_tracker.sv
